// ===== src/gdc_pkg.sv =====
// Shared types, constants and helper functions of the Gregorian date calculator.
package gdc_pkg;

    // Calendar limits.
    localparam int MAX_YEAR   = 9999;
    localparam int MAX_OFFSET = 1048575;

    // Internal widths: years up to 131071, day numbers up to 67108863.
    localparam int W_YEAR = 17;
    localparam int W_SER  = 26;
    localparam int W_SSER = 27;
    localparam int W_Q    = 11;

    // Floor division by 25 as a multiplication by a reciprocal.
    localparam int DIV25_MUL   = 5243;
    localparam int DIV25_SHIFT = 17;

    // Year estimate from a day number: n / 365.2425, with the product truncated.
    localparam int YEAR_RECIP       = 91868;
    localparam int YEAR_RECIP_SHIFT = 25;
    localparam int W_EST_PROD       = W_SER + W_YEAR;

    typedef logic [W_YEAR-1:0]        t_year;
    typedef logic [W_SER-1:0]         t_ser;
    typedef logic signed [W_SSER-1:0] t_sser;

    // Days in all years before year p + 1, evaluated on constants only.
    function automatic int f_days_before(input int p);
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    // Day number of 31/12/MAX_YEAR.
    localparam int MAX_SERIAL = f_days_before(MAX_YEAR);

    // Month length with the leap rule applied to February.
    function automatic logic [4:0] f_month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE, S_MUL_Y1, S_CHK1, S_MUL_P1, S_BASE1, S_WALK1,
        S_MUL_Y2, S_LEAP2, S_MUL_P2, S_BASE2, S_WALK2,
        S_RANGE, S_NSUB, S_EST, S_MUL_DN, S_DOWN, S_MUL_UP, S_UP,
        S_WALK3, S_DONE
    } t_state;

    // Datapath commands.
    typedef enum logic [4:0] {
        C_NONE, C_LOAD, C_MUL, C_CHK1, C_BASE1, C_WALK1, C_LOAD2, C_LEAP2,
        C_BASE2, C_WALK2, C_SHIFT, C_RERR, C_NSUB, C_EST, C_DEC, C_UP,
        C_YEAR, C_WALK3, C_OUT
    } t_cmd;

    // Datapath status toward the controller.
    typedef struct packed {
        logic date_ok;
        logic walk1_more;
        logic walk2_more;
        logic range_bad;
        logic d_gt_n;
        logic walk3_more;
        logic out_free;
    } t_status;

endpackage

// ===== src/gdc_ctrl.sv =====
// Controller state machine that sequences the date datapath.
module gdc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  gdc_pkg::t_status i_status,
    output logic            o_stall,
    output gdc_pkg::t_cmd   o_cmd
);
    import gdc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_MUL_Y1;
            S_MUL_Y1: n_state = S_CHK1;
            S_CHK1:   n_state = i_status.date_ok ? S_MUL_P1 : S_DONE;
            S_MUL_P1: n_state = S_BASE1;
            S_BASE1:  n_state = S_WALK1;
            S_WALK1:  if (!i_status.walk1_more) n_state = S_MUL_Y2;
            S_MUL_Y2: n_state = S_LEAP2;
            S_LEAP2:  n_state = S_MUL_P2;
            S_MUL_P2: n_state = S_BASE2;
            S_BASE2:  n_state = S_WALK2;
            S_WALK2:  if (!i_status.walk2_more) n_state = S_RANGE;
            S_RANGE:  n_state = i_status.range_bad ? S_DONE : S_NSUB;
            S_NSUB:   n_state = S_EST;
            S_EST:    n_state = S_MUL_DN;
            S_MUL_DN: n_state = S_DOWN;
            S_DOWN:   n_state = i_status.d_gt_n ? S_MUL_DN : S_MUL_UP;
            S_MUL_UP: n_state = S_UP;
            S_UP:     n_state = i_status.d_gt_n ? S_WALK3 : S_MUL_UP;
            S_WALK3:  if (!i_status.walk3_more) n_state = S_DONE;
            S_DONE:   if (i_status.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd   = C_NONE;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) o_cmd = C_LOAD;
            end
            S_MUL_Y1, S_MUL_P1, S_MUL_Y2, S_MUL_P2, S_MUL_DN, S_MUL_UP: o_cmd = C_MUL;
            S_CHK1:  o_cmd = C_CHK1;
            S_BASE1: o_cmd = C_BASE1;
            S_WALK1: o_cmd = i_status.walk1_more ? C_WALK1 : C_LOAD2;
            S_LEAP2: o_cmd = C_LEAP2;
            S_BASE2: o_cmd = C_BASE2;
            S_WALK2: o_cmd = i_status.walk2_more ? C_WALK2 : C_SHIFT;
            S_RANGE: o_cmd = i_status.range_bad ? C_RERR : C_NONE;
            S_NSUB:  o_cmd = C_NSUB;
            S_EST:   o_cmd = C_EST;
            S_DOWN:  o_cmd = i_status.d_gt_n ? C_DEC : C_UP;
            S_UP:    o_cmd = i_status.d_gt_n ? C_YEAR : C_UP;
            S_WALK3: o_cmd = i_status.walk3_more ? C_WALK3 : C_NONE;
            S_DONE:  if (i_status.out_free) o_cmd = C_OUT;
            default: o_cmd = C_NONE;
        endcase
    end

endmodule

// ===== src/gdc_datapath.sv =====
// Datapath: operand registers, divide-by-25 unit, day-number and month-walk logic.
module gdc_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gdc_pkg::t_cmd      i_cmd,
    output gdc_pkg::t_status   o_status,
    input  logic [4:0]         i_day,
    input  logic [3:0]         i_month,
    input  logic [13:0]        i_year,
    input  logic signed [20:0] i_offset,
    input  logic [4:0]         i_other_day,
    input  logic [3:0]         i_other_month,
    input  logic [13:0]        i_other_year,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_date_valid,
    output logic               o_range_error,
    output logic [4:0]         o_new_day,
    output logic [3:0]         o_new_month,
    output logic [13:0]        o_new_year,
    output logic [21:0]        o_day_number,
    output logic [21:0]        o_distance,
    output logic               o_is_later
);
    import gdc_pkg::*;

    localparam t_year MAX_YEAR_V   = t_year'(MAX_YEAR);
    localparam t_sser MAX_SERIAL_V = t_sser'(MAX_SERIAL);
    localparam t_sser MAX_OFF_V    = t_sser'(MAX_OFFSET);
    localparam t_ser  DIST_SAT     = t_ser'(22'h3FFFFF);

    // Captured transaction.
    logic [4:0]  r_d, r_od;
    logic [3:0]  r_m, r_om;
    logic [13:0] r_y, r_oy;
    t_sser       r_off;

    // Working registers.
    t_year          r_x;
    logic [W_Q-1:0] r_q;
    logic           r_leap, r_bad, r_rerr;
    t_ser           r_s1, r_s2, r_n, r_dprev;
    logic [3:0]     r_mi, r_nm;
    t_sser          r_ns;
    logic [8:0]     r_doy;
    t_year          r_ny;

    // Output register.
    logic        r_o_valid, r_o_date_valid, r_o_range_error, r_o_is_later;
    logic [4:0]  r_o_new_day;
    logic [3:0]  r_o_new_month;
    logic [13:0] r_o_new_year;
    logic [21:0] r_o_day_number, r_o_distance;

    // Combinational helpers.
    logic [W_YEAR-3:0]     w_a;
    logic [27:0]           w_prod;
    t_ser                  w_d;
    logic                  w_div100, w_leap;
    logic [W_EST_PROD-1:0] w_est_prod;
    logic [4:0]            w_mlen_mi, w_mlen_nm, w_mlen_in;
    t_sser                 w_off_ext, w_off_sat, w_diff, w_abs;
    t_ser                  w_dist;
    logic                  w_later;

    // Divide-by-25 product of the quarter year, the day count of whole years and the leap rule.
    always_comb begin
        w_a      = r_x[W_YEAR-1:2];
        w_prod   = 28'(w_a) * 28'(DIV25_MUL);
        w_d      = t_ser'(r_x) * t_ser'(365) + t_ser'(w_a) - t_ser'(r_q)
                   + t_ser'(r_q[W_Q-1:2]);
        w_div100 = (r_x[1:0] == 2'b00) && (15'(r_q) * 15'(25) == 15'(w_a));
        w_leap   = ((r_x[1:0] == 2'b00) && !w_div100) || (w_div100 && r_q[1:0] == 2'b00);
    end

    // Year estimate, month lengths and offset saturation.
    always_comb begin
        w_est_prod = W_EST_PROD'(r_n) * W_EST_PROD'(YEAR_RECIP);
        w_mlen_mi  = f_month_len(r_mi, r_leap);
        w_mlen_nm  = f_month_len(r_nm, r_leap);
        w_mlen_in  = f_month_len(r_m, w_leap);
        w_off_ext  = t_sser'(i_offset);
        if (w_off_ext > MAX_OFF_V) begin
            w_off_sat = MAX_OFF_V;
        end else if (w_off_ext < -MAX_OFF_V) begin
            w_off_sat = -MAX_OFF_V;
        end else begin
            w_off_sat = w_off_ext;
        end
    end

    // Distance and ordering of the two dates.
    always_comb begin
        w_diff = t_sser'({1'b0, r_s1}) - t_sser'({1'b0, r_s2});
        w_abs  = (w_diff < 0) ? -w_diff : w_diff;
        w_dist = (w_abs > t_sser'({1'b0, DIST_SAT})) ? DIST_SAT : w_abs[W_SER-1:0];
        if (r_y != r_oy) begin
            w_later = r_y > r_oy;
        end else if (r_m != r_om) begin
            w_later = r_m > r_om;
        end else begin
            w_later = r_d > r_od;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.date_ok = (r_d != 5'd0) && (r_m != 4'd0) && (r_y != 14'd0) &&
                           (r_m <= 4'd12) && (t_year'(r_y) <= MAX_YEAR_V) &&
                           (r_d <= w_mlen_in);
        o_status.walk1_more = r_mi < r_m;
        o_status.walk2_more = (r_mi < r_om) && (r_mi <= 4'd12);
        o_status.range_bad  = (r_ns < t_sser'(1)) || (r_ns > MAX_SERIAL_V);
        o_status.d_gt_n     = w_d > r_n;
        o_status.walk3_more = (r_nm < 4'd12) && (9'(w_mlen_nm) <= r_doy);
        o_status.out_free   = !r_o_valid || !i_stall;
    end

    // Working registers, stepped by the controller's commands.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            C_LOAD: begin
                r_d    <= i_day;
                r_m    <= i_month;
                r_y    <= i_year;
                r_od   <= i_other_day;
                r_om   <= i_other_month;
                r_oy   <= i_other_year;
                r_off  <= w_off_sat;
                r_x    <= t_year'(i_year);
                r_bad  <= 1'b0;
                r_rerr <= 1'b0;
            end
            C_MUL: r_q <= w_prod[DIV25_SHIFT+W_Q-1:DIV25_SHIFT];
            C_CHK1: begin
                r_leap <= w_leap;
                r_bad  <= !o_status.date_ok;
                r_x    <= r_x - t_year'(1);
            end
            C_BASE1: begin
                r_s1 <= w_d + t_ser'(r_d);
                r_mi <= 4'd1;
            end
            C_WALK1: begin
                r_s1 <= r_s1 + t_ser'(w_mlen_mi);
                r_mi <= r_mi + 4'd1;
            end
            C_LOAD2: r_x <= t_year'(r_oy);
            C_LEAP2: begin
                r_leap <= w_leap;
                r_x    <= (r_oy == 14'd0) ? t_year'(0) : t_year'(r_oy) - t_year'(1);
            end
            C_BASE2: begin
                r_s2 <= w_d + t_ser'(r_od);
                r_mi <= 4'd1;
            end
            C_WALK2: begin
                r_s2 <= r_s2 + t_ser'(w_mlen_mi);
                r_mi <= r_mi + 4'd1;
            end
            C_SHIFT: r_ns <= t_sser'({1'b0, r_s1}) + r_off;
            C_RERR:  r_rerr <= 1'b1;
            C_NSUB:  r_n <= t_ser'(r_ns - t_sser'(1));
            C_EST:   r_x <= w_est_prod[YEAR_RECIP_SHIFT+W_YEAR-1:YEAR_RECIP_SHIFT];
            C_DEC:   r_x <= r_x - t_year'(1);
            C_UP: begin
                r_dprev <= w_d;
                r_x     <= r_x + t_year'(1);
            end
            C_YEAR: begin
                r_ny   <= r_x;
                r_leap <= w_leap;
                r_doy  <= 9'(r_n - r_dprev);
                r_nm   <= 4'd1;
            end
            C_WALK3: begin
                r_doy <= r_doy - 9'(w_mlen_nm);
                r_nm  <= r_nm + 4'd1;
            end
            default: ;
        endcase
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd == C_OUT) begin
            r_o_date_valid  <= !r_bad;
            r_o_range_error <= !r_bad && r_rerr;
            r_o_new_day     <= (r_bad || r_rerr) ? 5'd0 : 5'(r_doy + 9'd1);
            r_o_new_month   <= (r_bad || r_rerr) ? 4'd0 : r_nm;
            r_o_new_year    <= (r_bad || r_rerr) ? 14'd0 : r_ny[13:0];
            r_o_day_number  <= r_bad ? 22'd0 : r_s1[21:0];
            r_o_distance    <= r_bad ? 22'd0 : w_dist[21:0];
            r_o_is_later    <= !r_bad && w_later;
        end
    end

    // Output valid: set when a result is loaded, cleared when the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd == C_OUT) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_date_valid  = r_o_date_valid;
    assign o_range_error = r_o_range_error;
    assign o_new_day     = r_o_new_day;
    assign o_new_month   = r_o_new_month;
    assign o_new_year    = r_o_new_year;
    assign o_day_number  = r_o_day_number;
    assign o_distance    = r_o_distance;
    assign o_is_later    = r_o_is_later;

    // A loaded result is offered in the next cycle.
    a_out_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == C_OUT |=> r_o_valid)
        else $error("result load did not raise valid");

    // An invalid first date gives an all-zero result.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_date_valid |-> r_o_range_error == 1'b0 &&
        r_o_new_day == 5'd0 && r_o_day_number == 22'd0 && r_o_distance == 22'd0 &&
        r_o_is_later == 1'b0)
        else $error("invalid date produced nonzero fields");

    // A range error clears the shifted date.
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_range_error |-> r_o_new_day == 5'd0 &&
        r_o_new_month == 4'd0 && r_o_new_year == 14'd0)
        else $error("range error with nonzero shifted date");

    // A result is never overwritten while it waits.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && i_stall |-> i_cmd != C_OUT)
        else $error("pending result overwritten");

endmodule

// ===== src/gregorian_date_calculator_core.sv =====
// Top level of the Gregorian date calculator: controller plus datapath.
//
// Input channel: i_valid / o_stall. A transaction is taken when i_valid is high
// and o_stall is low; o_stall is low only while the block waits for work.
// Output channel: o_valid / i_stall, one result per input transaction, held in
// an output register until the receiver takes it.
// The work after acceptance depends on the inputs: an invalid first date goes
// straight to the result, a shift out of range skips the year search and the
// last walk, and other transactions run every step. The month-by-month walks
// of the first date, the second date and the shifted date and the year search
// around the reciprocal estimate set how long a transaction takes. Each
// candidate year of the search passes through the shared divide-by-25 unit.
// One transaction is worked on at a time. After the result is loaded the block
// returns to idle and then takes the next transaction, even if the receiver
// still stalls the result.
// Reset (synchronous, active low) returns the controller to idle and drops
// o_valid. While the receiver stalls, the finished result stays unchanged and
// a following transaction waits in its last step until the register frees.
module gregorian_date_calculator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [4:0]         i_day,
    input  logic [3:0]         i_month,
    input  logic [13:0]        i_year,
    input  logic signed [20:0] i_offset,
    input  logic [4:0]         i_other_day,
    input  logic [3:0]         i_other_month,
    input  logic [13:0]        i_other_year,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_date_valid,
    output logic               o_range_error,
    output logic [4:0]         o_new_day,
    output logic [3:0]         o_new_month,
    output logic [13:0]        o_new_year,
    output logic [21:0]        o_day_number,
    output logic [21:0]        o_distance,
    output logic               o_is_later
);
    import gdc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer.
    gdc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd)
    );

    // Arithmetic and output register.
    gdc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_day         (i_day),
        .i_month       (i_month),
        .i_year        (i_year),
        .i_offset      (i_offset),
        .i_other_day   (i_other_day),
        .i_other_month (i_other_month),
        .i_other_year  (i_other_year),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_date_valid  (o_date_valid),
        .o_range_error (o_range_error),
        .o_new_day     (o_new_day),
        .o_new_month   (o_new_month),
        .o_new_year    (o_new_year),
        .o_day_number  (o_day_number),
        .o_distance    (o_distance),
        .o_is_later    (o_is_later)
    );

endmodule

// ===== tb/gregorian_date_calculator_core_test.sv =====
// Self-checking testbench of the Gregorian date calculator core.
module gregorian_date_calculator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gdc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1100;

    // One expected or observed result.
    typedef struct packed {
        logic        date_valid;
        logic        range_error;
        logic [4:0]  new_day;
        logic [3:0]  new_month;
        logic [13:0] new_year;
        logic [21:0] day_number;
        logic [21:0] distance;
        logic        is_later;
    } t_date_result;

    // One stimulus row; has_gold marks rows with a typed-in result.
    typedef struct {
        logic [4:0]         day;
        logic [3:0]         month;
        logic [13:0]        year;
        logic signed [20:0] offset;
        logic [4:0]         other_day;
        logic [3:0]         other_month;
        logic [13:0]        other_year;
        bit                 has_gold;
        t_date_result       gold;
    } t_date_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [4:0]         i_day = '0;
    logic [3:0]         i_month = '0;
    logic [13:0]        i_year = '0;
    logic signed [20:0] i_offset = '0;
    logic [4:0]         i_other_day = '0;
    logic [3:0]         i_other_month = '0;
    logic [13:0]        i_other_year = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_date_valid;
    logic               o_range_error;
    logic [4:0]         o_new_day;
    logic [3:0]         o_new_month;
    logic [13:0]        o_new_year;
    logic [21:0]        o_day_number;
    logic [21:0]        o_distance;
    logic               o_is_later;

    t_date_result expected_dates[$];
    int           cycle_count = 0;
    int           fail_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           long_hold = 1'b0;

    gregorian_date_calculator_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Leap rule of the Gregorian calendar.
    function automatic bit leap_year(input longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint month_days(input longint m, input longint y);
        if (m < 1 || m > 12) return 0;
        if (m == 2) return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    // Day number with 1/1/1 as day 1; months above 12 add nothing.
    function automatic longint serial_day(input longint d, input longint m, input longint y);
        longint s;
        longint p;
        s = d;
        for (longint i = 1; i < m && i <= 12; i++) s += month_days(i, y);
        if (y >= 1) begin
            p = y - 1;
            s += 365 * p + p / 4 - p / 100 + p / 400;
        end
        return s;
    endfunction

    // Computes the full result of one transaction.
    function automatic t_date_result shift_date(input t_date_row r);
        t_date_result res;
        longint off, s1, s2, ns, maxs, diff, n, q400, q100, q4, q1, rem, ny, nm, doy;
        res = '0;
        if (r.day == 0 || r.month == 0 || r.year == 0 || r.month > 12 ||
            r.year > MAX_YEAR || r.day > month_days(r.month, r.year)) return res;
        off = r.offset;
        if (off > MAX_OFFSET) off = MAX_OFFSET;
        if (off < -MAX_OFFSET) off = -MAX_OFFSET;
        s1 = serial_day(r.day, r.month, r.year);
        s2 = serial_day(r.other_day, r.other_month, r.other_year);
        ns = s1 + off;
        maxs = serial_day(31, 12, MAX_YEAR);
        res.date_valid = 1'b1;
        if (ns < 1 || ns > maxs) begin
            res.range_error = 1'b1;
        end else begin
            n = ns - 1;
            q400 = n / 146097;
            rem = n % 146097;
            q100 = rem / 36524;
            if (q100 == 4) q100 = 3;
            rem -= q100 * 36524;
            q4 = rem / 1461;
            rem %= 1461;
            q1 = rem / 365;
            if (q1 == 4) q1 = 3;
            rem -= q1 * 365;
            ny = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
            doy = rem;
            nm = 1;
            while (nm < 12 && doy >= month_days(nm, ny)) begin
                doy -= month_days(nm, ny);
                nm++;
            end
            res.new_day = 5'(doy + 1);
            res.new_month = 4'(nm);
            res.new_year = 14'(ny);
        end
        diff = s1 - s2;
        if (diff < 0) diff = -diff;
        if (diff > 22'h3FFFFF) diff = 22'h3FFFFF;
        res.day_number = 22'(s1);
        res.distance = 22'(diff);
        if (r.year != r.other_year) res.is_later = r.year > r.other_year;
        else if (r.month != r.other_month) res.is_later = r.month > r.other_month;
        else res.is_later = r.day > r.other_day;
        return res;
    endfunction

    function automatic t_date_row make_row(input int d, input int m, input int y, input int off,
                                           input int od, input int om, input int oy);
        t_date_row r;
        r.day = 5'(d); r.month = 4'(m); r.year = 14'(y); r.offset = 21'(off);
        r.other_day = 5'(od); r.other_month = 4'(om); r.other_year = 14'(oy);
        r.has_gold = 1'b0;
        r.gold = '0;
        return r;
    endfunction

    // Random row: mostly valid dates, some raw noise, varied offset sizes.
    function automatic t_date_row random_row();
        t_date_row r;
        int m, y;
        if ($urandom_range(0, 9) == 0) begin
            r = make_row($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            y = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) :
                ($urandom_range(0, 3) == 0) ? $urandom_range(9990, 9999) :
                $urandom_range(1, MAX_YEAR);
            m = $urandom_range(1, 12);
            r = make_row($urandom_range(1, int'(month_days(m, y))), m, y, 0,
                         $urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(1, 9999));
            case ($urandom_range(0, 3))
                0: r.offset = $signed(21'($urandom_range(0, 4))) - 21'sd2;
                1: r.offset = $signed(21'($urandom_range(0, 800))) - 21'sd400;
                default: r.offset = 21'($urandom);
            endcase
            if ($urandom_range(0, 7) == 0) begin
                r.other_year = 14'(y);
                r.other_month = ($urandom_range(0, 1) == 0) ? 4'(m) : 4'($urandom);
                r.other_day = 5'($urandom);
            end
        end
        return r;
    endfunction

    // Drives one row and waits until it is accepted; valid stays high afterward.
    task automatic send_row(input t_date_row r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_day <= r.day; i_month <= r.month; i_year <= r.year; i_offset <= r.offset;
        i_other_day <= r.other_day; i_other_month <= r.other_month;
        i_other_year <= r.other_year;
        expected_dates.push_back(r.has_gold ? r.gold : shift_date(r));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge i_clk);
    endtask

    // Receiver stall pattern, with an optional long hold-off.
    always @(posedge i_clk) begin
        if (long_hold) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_date_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_dates.size() == 0) begin
                $error("result with no transaction pending");
                fail_count++;
            end else begin
                exp_r = expected_dates.pop_front();
                if (o_date_valid !== exp_r.date_valid) begin
                    $error("date_valid exp %0d got %0d", exp_r.date_valid, o_date_valid);
                    fail_count++;
                end
                if (o_range_error !== exp_r.range_error) begin
                    $error("range_error exp %0d got %0d", exp_r.range_error, o_range_error);
                    fail_count++;
                end
                if (o_new_day !== exp_r.new_day) begin
                    $error("new_day exp %0d got %0d", exp_r.new_day, o_new_day);
                    fail_count++;
                end
                if (o_new_month !== exp_r.new_month) begin
                    $error("new_month exp %0d got %0d", exp_r.new_month, o_new_month);
                    fail_count++;
                end
                if (o_new_year !== exp_r.new_year) begin
                    $error("new_year exp %0d got %0d", exp_r.new_year, o_new_year);
                    fail_count++;
                end
                if (o_day_number !== exp_r.day_number) begin
                    $error("day_number exp %0d got %0d", exp_r.day_number, o_day_number);
                    fail_count++;
                end
                if (o_distance !== exp_r.distance) begin
                    $error("distance exp %0d got %0d", exp_r.distance, o_distance);
                    fail_count++;
                end
                if (o_is_later !== exp_r.is_later) begin
                    $error("is_later exp %0d got %0d", exp_r.is_later, o_is_later);
                    fail_count++;
                end
            end
        end
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Directed table, then random phases, then the final verdict.
    initial begin
        t_date_row rows[$];
        t_date_row r;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Invalid first dates give an all-zero result.
        r = make_row(0, 1, 1, 0, 1, 1, 1);          r.has_gold = 1; rows.push_back(r);
        r = make_row(1, 0, 1, 0, 1, 1, 1);          r.has_gold = 1; rows.push_back(r);
        r = make_row(1, 1, 0, 0, 1, 1, 1);          r.has_gold = 1; rows.push_back(r);
        r = make_row(1, 13, 1, 0, 1, 1, 1);         r.has_gold = 1; rows.push_back(r);
        r = make_row(31, 15, 16383, -1, 31, 15, 16383); r.has_gold = 1; rows.push_back(r);
        r = make_row(1, 1, 10000, 0, 1, 1, 1);      r.has_gold = 1; rows.push_back(r);
        r = make_row(29, 2, 1900, 0, 1, 1, 1);      r.has_gold = 1; rows.push_back(r);
        r = make_row(31, 4, 2023, 0, 1, 1, 1);      r.has_gold = 1; rows.push_back(r);
        // First day, no offset, equal dates.
        r = make_row(1, 1, 1, 0, 1, 1, 1);          r.has_gold = 1;
        r.gold = '{1'b1, 1'b0, 5'd1, 4'd1, 14'd1, 22'd1, 22'd0, 1'b0}; rows.push_back(r);
        // Decrement below the first day leaves the range.
        r = make_row(1, 1, 1, -1, 1, 1, 1);         r.has_gold = 1;
        r.gold = '{1'b1, 1'b1, 5'd0, 4'd0, 14'd0, 22'd1, 22'd0, 1'b0}; rows.push_back(r);
        // Increment past the last day leaves the range.
        r = make_row(31, 12, 9999, 1, 31, 12, 9999); r.has_gold = 1;
        r.gold = '{1'b1, 1'b1, 5'd0, 4'd0, 14'd0, 22'(MAX_SERIAL), 22'd0, 1'b0};
        rows.push_back(r);
        // Leap days, increments, decrements, extreme and saturated offsets.
        rows.push_back(make_row(29, 2, 2000, 1, 1, 3, 2000));
        rows.push_back(make_row(29, 2, 2024, -1, 28, 2, 2024));
        rows.push_back(make_row(28, 2, 2023, 1, 1, 1, 1));
        rows.push_back(make_row(1, 3, 2100, -1, 31, 12, 9999));
        rows.push_back(make_row(31, 12, 1999, 1, 31, 12, 1999));
        rows.push_back(make_row(1, 1, 5000, 1048575, 1, 1, 5000));
        rows.push_back(make_row(1, 1, 5000, -1048575, 2, 1, 5000));
        rows.push_back(make_row(1, 1, 5000, -1048576, 1, 2, 5000));
        rows.push_back(make_row(15, 6, 1, 1048575, 1, 1, 1));
        // Malformed second dates.
        rows.push_back(make_row(31, 12, 9999, 0, 0, 0, 0));
        rows.push_back(make_row(5, 5, 100, 7, 31, 15, 16383));
        rows.push_back(make_row(5, 5, 100, 7, 31, 15, 100));
        rows.push_back(make_row(5, 5, 100, 7, 0, 5, 100));
        foreach (rows[i]) send_row(rows[i]);
        drain_results();

        // Random phases with different idle patterns.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int k = 0; k < N_RANDOM / 4; k++) send_row(random_row());
            // Sender pause until every expectation has arrived.
            drain_results();
        end

        // Long receiver hold-off while the sender keeps offering.
        send_idle_pct = 0;
        recv_stall_pct = 20;
        fork
            begin
                long_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end
            for (int k = 0; k < 8; k++) send_row(random_row());
        join
        recv_stall_pct = 0;
        drain_results();
        repeat (100) @(posedge i_clk);

        if (fail_count == 0 && expected_dates.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
